/* src/hla_pkg.sv */
`timescale 1ns / 1ps
package hla_pkg;

  // request action codes
  localparam logic [1:0] ACT_VOTE  = 2'd0;
  localparam logic [1:0] ACT_QUERY = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_IMAGE_WIDTH    = 3'd0;
  localparam logic [2:0] CFG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [2:0] CFG_RHO_OFFSET     = 3'd2;
  localparam logic [2:0] CFG_ACCU_ROWS      = 3'd3;
  localparam logic [2:0] CFG_PEAK_THRESHOLD = 3'd4;

  // grey level a pixel must exceed to vote
  localparam logic [7:0] PIX_LIMIT = 8'd250;

  // widths that cover the whole parameter range
  localparam int ROW_W  = 12;
  localparam int ROWS_W = 13;
  localparam int ANG_W  = 9;

  typedef struct packed {
    logic [1:0]  action;
    logic [9:0]  pixel_x;
    logic [9:0]  pixel_y;
    logic [7:0]  pixel_value;
    logic [10:0] rho_index;
    logic [7:0]  theta_index;
  } hla_in_t;

  typedef struct packed {
    logic [15:0] vote_count;
    logic        is_peak;
  } hla_out_t;

  typedef enum logic [1:0] {
    K_VOTE,
    K_QUERY,
    K_MISS,
    K_CLEAR
  } hla_kind_t;

  // classified job passed from front to back
  typedef struct packed {
    hla_kind_t          kind;
    logic signed [10:0] dx;
    logic signed [10:0] dy;
    logic [23:0]        offset;
    logic [ROWS_W-1:0]  rows;
    logic [ROW_W-1:0]   row;
    logic [ANG_W-1:0]   theta;
    logic [15:0]        threshold;
  } hla_cmd_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_VOTE,
    S_QUERY
  } hla_state_t;

  // sine of 0..90 degrees in Q1.14
  function automatic logic signed [15:0] hla_quarter_sin(input logic [6:0] k);
    logic signed [15:0] v;
    case (k)
      7'd0: v = 16'sd0;        7'd1: v = 16'sd286;      7'd2: v = 16'sd572;
      7'd3: v = 16'sd857;      7'd4: v = 16'sd1143;     7'd5: v = 16'sd1428;
      7'd6: v = 16'sd1713;     7'd7: v = 16'sd1997;     7'd8: v = 16'sd2280;
      7'd9: v = 16'sd2563;     7'd10: v = 16'sd2845;    7'd11: v = 16'sd3126;
      7'd12: v = 16'sd3406;    7'd13: v = 16'sd3686;    7'd14: v = 16'sd3964;
      7'd15: v = 16'sd4240;    7'd16: v = 16'sd4516;    7'd17: v = 16'sd4790;
      7'd18: v = 16'sd5063;    7'd19: v = 16'sd5334;    7'd20: v = 16'sd5604;
      7'd21: v = 16'sd5872;    7'd22: v = 16'sd6138;    7'd23: v = 16'sd6402;
      7'd24: v = 16'sd6664;    7'd25: v = 16'sd6924;    7'd26: v = 16'sd7182;
      7'd27: v = 16'sd7438;    7'd28: v = 16'sd7692;    7'd29: v = 16'sd7943;
      7'd30: v = 16'sd8192;    7'd31: v = 16'sd8438;    7'd32: v = 16'sd8682;
      7'd33: v = 16'sd8923;    7'd34: v = 16'sd9162;    7'd35: v = 16'sd9397;
      7'd36: v = 16'sd9630;    7'd37: v = 16'sd9860;    7'd38: v = 16'sd10087;
      7'd39: v = 16'sd10311;   7'd40: v = 16'sd10531;   7'd41: v = 16'sd10749;
      7'd42: v = 16'sd10963;   7'd43: v = 16'sd11174;   7'd44: v = 16'sd11381;
      7'd45: v = 16'sd11585;   7'd46: v = 16'sd11786;   7'd47: v = 16'sd11982;
      7'd48: v = 16'sd12176;   7'd49: v = 16'sd12365;   7'd50: v = 16'sd12551;
      7'd51: v = 16'sd12733;   7'd52: v = 16'sd12911;   7'd53: v = 16'sd13085;
      7'd54: v = 16'sd13255;   7'd55: v = 16'sd13421;   7'd56: v = 16'sd13583;
      7'd57: v = 16'sd13741;   7'd58: v = 16'sd13894;   7'd59: v = 16'sd14044;
      7'd60: v = 16'sd14189;   7'd61: v = 16'sd14330;   7'd62: v = 16'sd14466;
      7'd63: v = 16'sd14598;   7'd64: v = 16'sd14726;   7'd65: v = 16'sd14849;
      7'd66: v = 16'sd14968;   7'd67: v = 16'sd15082;   7'd68: v = 16'sd15191;
      7'd69: v = 16'sd15296;   7'd70: v = 16'sd15396;   7'd71: v = 16'sd15491;
      7'd72: v = 16'sd15582;   7'd73: v = 16'sd15668;   7'd74: v = 16'sd15749;
      7'd75: v = 16'sd15826;   7'd76: v = 16'sd15897;   7'd77: v = 16'sd15964;
      7'd78: v = 16'sd16026;   7'd79: v = 16'sd16083;   7'd80: v = 16'sd16135;
      7'd81: v = 16'sd16182;   7'd82: v = 16'sd16225;   7'd83: v = 16'sd16262;
      7'd84: v = 16'sd16294;   7'd85: v = 16'sd16322;   7'd86: v = 16'sd16344;
      7'd87: v = 16'sd16362;   7'd88: v = 16'sd16374;   7'd89: v = 16'sd16382;
      7'd90: v = 16'sd16384;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  // sine of 0..719 degrees by quadrant symmetry
  function automatic logic signed [15:0] hla_sin_deg(input logic [9:0] d);
    logic [9:0]         r;
    logic signed [15:0] v;
    r = (d >= 10'd360) ? d - 10'd360 : d;
    if (r <= 10'd90) begin
      v = hla_quarter_sin(7'(r));
    end else if (r <= 10'd180) begin
      v = hla_quarter_sin(7'(10'd180 - r));
    end else if (r <= 10'd270) begin
      v = -hla_quarter_sin(7'(r - 10'd180));
    end else begin
      v = -hla_quarter_sin(7'(10'd360 - r));
    end
    return v;
  endfunction

endpackage

/* src/hla_front.sv */
`timescale 1ns / 1ps
module hla_front #(
  parameter int ANGLES       = 180,
  parameter int MAX_RHO_ROWS = 2048
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  hla_pkg::hla_in_t  request,
  output logic              busy,
  input  logic              cfg_valid,
  input  logic [2:0]        cfg_index,
  input  logic [23:0]       cfg_data,
  input  logic              init_done,
  input  logic              q_full,
  output logic              push,
  output hla_pkg::hla_cmd_t cmd
);

  logic [10:0] image_width;
  logic [10:0] image_height;
  logic [23:0] rho_offset_q14;
  logic [10:0] accu_rows;
  logic [15:0] peak_threshold;

  logic [hla_pkg::ROWS_W-1:0] rows_use;
  logic                       keep;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= 11'd640;
      image_height   <= 11'd480;
      rho_offset_q14 <= 24'd7414552;
      accu_rows      <= 11'd905;
      peak_threshold <= 16'd100;
    end else if (cfg_valid) begin
      case (cfg_index)
        hla_pkg::CFG_IMAGE_WIDTH:    image_width    <= cfg_data[10:0];
        hla_pkg::CFG_IMAGE_HEIGHT:   image_height   <= cfg_data[10:0];
        hla_pkg::CFG_RHO_OFFSET:     rho_offset_q14 <= cfg_data;
        hla_pkg::CFG_ACCU_ROWS:      accu_rows      <= cfg_data[10:0];
        hla_pkg::CFG_PEAK_THRESHOLD: peak_threshold <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // rows in use, capped at the store size
  always_comb begin
    if ({2'b0, accu_rows} < hla_pkg::ROWS_W'(MAX_RHO_ROWS)) begin
      rows_use = {2'b0, accu_rows};
    end else begin
      rows_use = hla_pkg::ROWS_W'(MAX_RHO_ROWS);
    end
  end

  // classify the request into a job for the back end
  always_comb begin
    cmd.dx        = $signed({1'b0, request.pixel_x}) - $signed({1'b0, image_width[10:1]});
    cmd.dy        = $signed({1'b0, request.pixel_y}) - $signed({1'b0, image_height[10:1]});
    cmd.offset    = rho_offset_q14;
    cmd.rows      = rows_use;
    cmd.row       = hla_pkg::ROW_W'(request.rho_index);
    cmd.theta     = hla_pkg::ANG_W'(request.theta_index);
    cmd.threshold = peak_threshold;
    cmd.kind      = hla_pkg::K_VOTE;
    keep          = 1'b0;
    case (request.action)
      hla_pkg::ACT_VOTE: begin
        cmd.kind = hla_pkg::K_VOTE;
        keep     = request.pixel_value > hla_pkg::PIX_LIMIT;
      end
      hla_pkg::ACT_QUERY: begin
        keep = 1'b1;
        if (({2'b0, request.rho_index} < rows_use) &&
            ({1'b0, request.theta_index} < hla_pkg::ANG_W'(ANGLES))) begin
          cmd.kind = hla_pkg::K_QUERY;
        end else begin
          cmd.kind = hla_pkg::K_MISS;
        end
      end
      hla_pkg::ACT_CLEAR: begin
        cmd.kind = hla_pkg::K_CLEAR;
        keep     = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign busy = !init_done || q_full;
  assign push = start && !busy && keep;

endmodule

/* src/hla_queue.sv */
`timescale 1ns / 1ps
module hla_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hla_pkg::hla_cmd_t push_cmd,
  input  logic              pop,
  output hla_pkg::hla_cmd_t head,
  output logic              empty,
  output logic              full
);

  hla_pkg::hla_cmd_t slot [2];
  logic              rd_ptr;
  logic              wr_ptr;
  logic [1:0]        count;

  // two entry job queue
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_cmd;
    end
  end

  assign head  = slot[rd_ptr];
  assign empty = count == 2'd0;
  assign full  = count == 2'd2;

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("job queue popped while empty");

endmodule

/* src/hla_back.sv */
`timescale 1ns / 1ps
module hla_back #(
  parameter int ANGLES        = 180,
  parameter int MAX_RHO_ROWS  = 2048,
  parameter int WINDOW_RADIUS = 4,
  parameter int COUNT_BITS    = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  hla_pkg::hla_cmd_t head,
  input  logic              empty,
  output logic              pop,
  output logic              init_done,
  output logic              done,
  output hla_pkg::hla_out_t result
);

  localparam int DEPTH = MAX_RHO_ROWS * ANGLES;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_RHO_ROWS);
  localparam int TW    = (ANGLES > 1) ? $clog2(ANGLES) : 1;
  localparam int WN    = (2 * WINDOW_RADIUS + 1) * (2 * WINDOW_RADIUS + 1);
  localparam int QW    = $clog2(WN + 3);
  localparam logic signed [4:0] WR = 5'(WINDOW_RADIUS);

  hla_pkg::hla_state_t state;
  hla_pkg::hla_state_t state_next;
  hla_pkg::hla_cmd_t   job;

  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [COUNT_BITS-1:0] rd_data;
  logic [AW-1:0]         ra;
  logic [AW-1:0]         wa;
  logic [COUNT_BITS-1:0] wd;
  logic                  we;

  logic [AW-1:0] clr_addr;

  // vote pipeline
  logic [TW-1:0]      vt;
  logic               vissue;
  logic [2:0]         vdrain;
  logic               pa_valid;
  logic [TW-1:0]      pa_t;
  logic signed [26:0] pa_pc;
  logic signed [26:0] pa_ps;
  logic signed [28:0] pb_sum;
  logic               pb_ok;
  logic               pb_valid;
  logic [RW-1:0]      pb_row;
  logic [TW-1:0]      pb_t;
  logic               pc_valid;
  logic [AW-1:0]      pc_addr;
  logic               pd_valid;
  logic [AW-1:0]      pd_addr;

  // query sweep
  logic [QW-1:0]         qstep;
  logic [AW-1:0]         q_base;
  logic signed [4:0]     wy;
  logic signed [4:0]     wx;
  logic signed [13:0]    rr;
  logic signed [10:0]    tt;
  logic signed [AW:0]    woff;
  logic [AW-1:0]         q_addr;
  logic                  q_win;
  logic                  q_ok;
  logic                  rq_center;
  logic                  rq_win;
  logic [COUNT_BITS-1:0] c_reg;
  logic                  bigger;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hla_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and queue pop
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    case (state)
      hla_pkg::S_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = hla_pkg::S_IDLE;
        end
      end
      hla_pkg::S_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          case (head.kind)
            hla_pkg::K_VOTE:  state_next = hla_pkg::S_VOTE;
            hla_pkg::K_QUERY: state_next = hla_pkg::S_QUERY;
            hla_pkg::K_CLEAR: state_next = hla_pkg::S_CLEAR;
            default:          state_next = hla_pkg::S_IDLE;
          endcase
        end
      end
      hla_pkg::S_VOTE: begin
        if (!vissue && vdrain == 3'd0) begin
          state_next = hla_pkg::S_IDLE;
        end
      end
      hla_pkg::S_QUERY: begin
        if (qstep == QW'(WN + 2)) begin
          state_next = hla_pkg::S_IDLE;
        end
      end
      default: state_next = hla_pkg::S_IDLE;
    endcase
  end

  // control counters and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      init_done <= 1'b0;
      clr_addr  <= '0;
      vissue    <= 1'b0;
      vdrain    <= 3'd0;
      qstep     <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        hla_pkg::S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            init_done <= 1'b1;
          end
        end
        hla_pkg::S_IDLE: begin
          clr_addr <= '0;
          vissue   <= 1'b1;
          vdrain   <= 3'd0;
          qstep    <= '0;
          if (!empty && head.kind == hla_pkg::K_MISS) begin
            done <= 1'b1;
          end
        end
        hla_pkg::S_VOTE: begin
          if (vissue && vt == TW'(ANGLES - 1)) begin
            vissue <= 1'b0;
            vdrain <= 3'd4;
          end else if (vdrain != 3'd0) begin
            vdrain <= vdrain - 3'd1;
          end
        end
        hla_pkg::S_QUERY: begin
          qstep <= qstep + QW'(1);
          if (qstep == QW'(WN + 2)) begin
            done <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // job latch, angle counter and window counters
  always_ff @(posedge clk) begin
    if (pop) begin
      job    <= head;
      q_base <= AW'(head.row) * AW'(ANGLES) + AW'(head.theta);
      vt     <= '0;
      wy     <= -WR;
      wx     <= -WR;
    end else begin
      if (vissue && state == hla_pkg::S_VOTE) begin
        vt <= vt + TW'(1);
      end
      if (state == hla_pkg::S_QUERY && q_win) begin
        if (wx == WR) begin
          wx <= -WR;
          wy <= wy + 5'sd1;
        end else begin
          wx <= wx + 5'sd1;
        end
      end
    end
  end

  // vote stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      pa_valid <= 1'b0;
      pb_valid <= 1'b0;
      pc_valid <= 1'b0;
      pd_valid <= 1'b0;
    end else begin
      pa_valid <= state == hla_pkg::S_VOTE && vissue;
      pb_valid <= pa_valid && pb_ok;
      pc_valid <= pb_valid;
      pd_valid <= pc_valid;
    end
  end

  // rho sum and row range check
  always_comb begin
    pb_sum = 29'(pa_pc) + 29'(pa_ps) + $signed({5'b0, job.offset});
    pb_ok  = !pb_sum[28] && (pb_sum[27:14] < 14'(job.rows));
  end

  // vote stages: products, row, address, read
  always_ff @(posedge clk) begin
    pa_t    <= vt;
    pa_pc   <= 27'(job.dx) * 27'(hla_pkg::hla_sin_deg(10'(vt) + 10'd90));
    pa_ps   <= 27'(job.dy) * 27'(hla_pkg::hla_sin_deg(10'(vt)));
    pb_row  <= RW'(pb_sum[27:14]);
    pb_t    <= pa_t;
    pc_addr <= AW'(pb_row) * AW'(ANGLES) + AW'(pb_t);
    pd_addr <= pc_addr;
  end

  // window position, clipping and address
  always_comb begin
    q_win  = qstep != '0 && qstep <= QW'(WN);
    rr     = $signed({2'b0, job.row}) + 14'(wy);
    tt     = $signed({2'b0, job.theta}) + 11'(wx);
    q_ok   = !rr[13] && (rr[12:0] < job.rows) && !tt[10] && (tt[9:0] < 10'(ANGLES));
    woff   = (AW + 1)'(wy) * (AW + 1)'(ANGLES) + (AW + 1)'(wx);
    q_addr = (qstep == '0) ? q_base : AW'($signed({1'b0, q_base}) + woff);
  end

  // peak search over the window
  always_ff @(posedge clk) begin
    if (rst) begin
      rq_center <= 1'b0;
      rq_win    <= 1'b0;
    end else begin
      rq_center <= state == hla_pkg::S_QUERY && qstep == '0;
      rq_win    <= state == hla_pkg::S_QUERY && q_win && q_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rq_center) begin
      c_reg  <= rd_data;
      bigger <= 1'b0;
    end else if (rq_win && rd_data > c_reg) begin
      bigger <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == hla_pkg::S_IDLE) begin
      result <= '0;
    end else if (state == hla_pkg::S_QUERY) begin
      result.vote_count <= 16'(c_reg);
      result.is_peak    <= (32'(c_reg) >= 32'(job.threshold)) && !bigger;
    end
  end

  // count store ports
  always_comb begin
    ra = (state == hla_pkg::S_QUERY) ? q_addr : pc_addr;
    if (state == hla_pkg::S_CLEAR) begin
      we = 1'b1;
      wa = clr_addr;
      wd = '0;
    end else begin
      we = pd_valid;
      wa = pd_addr;
      wd = (rd_data == {COUNT_BITS{1'b1}}) ? rd_data : rd_data + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[ra];
  end

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == hla_pkg::S_QUERY || $past(state) == hla_pkg::S_IDLE)
    else $error("result strobe outside query or miss");

  a_query_no_write: assert property (@(posedge clk) disable iff (rst)
    state == hla_pkg::S_QUERY |-> !we)
    else $error("store written during a query sweep");

  a_init_clear: assert property (@(posedge clk) disable iff (rst)
    !init_done |-> state == hla_pkg::S_CLEAR)
    else $error("work started before the store was cleared");

endmodule

/* src/hough_line_accumulator.sv */
`timescale 1ns / 1ps
// Hough line accumulator over a rho-theta grid of vote counts.
// Requests: start with the request struct, taken when busy is low. A vote
//   request with a grey level above 250 adds one vote per angle column whose
//   rho row is in range, a query request returns one result, a clear request
//   zeroes the store. Other requests are taken and dropped with no result.
// Results: done is high for one cycle with result (count and peak flag).
//   The receiver cannot stall, so results are never held back.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
//   always high, writes take effect on the next cycle.
// Store work: a vote does one read-modify-write of the count store per
//   angle. A query does one store read per window cell, and done comes in
//   the cycle after the sweep; an out of range query is answered with a
//   zero result and no store read. A clear writes one store entry per
//   cycle.
// A two entry job queue sits between request intake and the store engine.
// Reset: after rst the store is cleared in the same sweep, with busy high
//   until the sweep ends; registers return to their defaults.
module hough_line_accumulator #(
  parameter int ANGLES        = 180,
  parameter int MAX_RHO_ROWS  = 2048,
  parameter int WINDOW_RADIUS = 4,
  parameter int COUNT_BITS    = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  hla_pkg::hla_in_t  request,
  output logic              busy,
  output logic              done,
  output hla_pkg::hla_out_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [23:0]       cfg_data
);

  hla_pkg::hla_cmd_t push_cmd;
  hla_pkg::hla_cmd_t head;
  logic              push;
  logic              pop;
  logic              empty;
  logic              full;
  logic              init_done;

  assign cfg_ready = 1'b1;

  // request intake and configuration
  hla_front #(
    .ANGLES       (ANGLES),
    .MAX_RHO_ROWS (MAX_RHO_ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .busy      (busy),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .init_done (init_done),
    .q_full    (full),
    .push      (push),
    .cmd       (push_cmd)
  );

  // job queue
  hla_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  // store engine
  hla_back #(
    .ANGLES        (ANGLES),
    .MAX_RHO_ROWS  (MAX_RHO_ROWS),
    .WINDOW_RADIUS (WINDOW_RADIUS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .init_done (init_done),
    .done      (done),
    .result    (result)
  );

endmodule
